[hdl/hde_pkg.sv]
package hde_pkg;

    localparam int unsigned MaxBinsDefault   = 4096;
    localparam int unsigned MaxLevelsDefault = 8;
    localparam int unsigned BinFracBits      = 15;

    localparam int unsigned BinW   = 16;
    localparam int unsigned SumW   = 48;
    localparam int unsigned WideW  = 64;
    localparam int unsigned OutW   = 48;
    localparam int unsigned CdW    = 30;
    localparam int unsigned ChiNumW = 50;
    localparam int unsigned ChiDenW = 17;

    localparam logic [2:0] MODE_L1    = 3'd0;
    localparam logic [2:0] MODE_L2    = 3'd1;
    localparam logic [2:0] MODE_EMD   = 3'd2;
    localparam logic [2:0] MODE_INTER = 3'd3;
    localparam logic [2:0] MODE_CHI   = 3'd4;

    localparam logic [1:0] CFG_MODE   = 2'd0;
    localparam logic [1:0] CFG_BASE   = 2'd1;
    localparam logic [1:0] CFG_LEVELS = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_TERM,
        ST_DIV,
        ST_ACC,
        ST_LVL,
        ST_SQRT,
        ST_WADD,
        ST_NEXT,
        ST_FDIV,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic frame_clear;
        logic load_item;
        logic calc_term;
        logic div_start;
        logic div_step;
        logic acc;
        logic lvl_start;
        logic sqrt_step;
        logic wadd;
        logic next_level;
        logic fdiv_start;
        logic fdiv_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic div_done;
        logic is_chi;
        logic is_l2;
        logic single;
        logic level_end;
        logic frame_end;
        logic sqrt_done;
        logic fdiv_done;
    } t_status;

endpackage

[hdl/hde_ctrl.sv]
module hde_ctrl
    import hde_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_cfg_we,
    input  logic    i_in_valid,
    input  logic    i_out_free,
    input  t_status i_st,
    output logic    o_in_ready,
    output t_cmd    o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_in_valid) n_state = ST_TERM;
            ST_TERM: n_state = i_st.is_chi ? ST_DIV : ST_ACC;
            ST_DIV:  if (i_st.div_done) n_state = ST_ACC;
            ST_ACC:  begin
                if (!i_st.level_end) begin
                    n_state = ST_IDLE;
                end else if (i_st.single) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_LVL;
                end
            end
            ST_LVL:  n_state = i_st.is_l2 ? ST_SQRT : ST_WADD;
            ST_SQRT: if (i_st.sqrt_done) n_state = ST_WADD;
            ST_WADD: n_state = ST_NEXT;
            ST_NEXT: n_state = i_st.frame_end ? ST_FDIV : ST_IDLE;
            ST_FDIV: if (i_st.fdiv_done) n_state = ST_OUT;
            ST_OUT:  if (i_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load_item = i_in_valid;
            end
            ST_TERM: begin
                o_cmd.calc_term = 1'b1;
                o_cmd.div_start = i_st.is_chi;
            end
            ST_DIV:  o_cmd.div_step = 1'b1;
            ST_ACC: begin
                o_cmd.acc = 1'b1;
            end
            ST_LVL:  o_cmd.lvl_start = 1'b1;
            ST_SQRT: o_cmd.sqrt_step = 1'b1;
            ST_WADD: o_cmd.wadd = 1'b1;
            ST_NEXT: begin
                o_cmd.next_level = 1'b1;
                o_cmd.fdiv_start = i_st.frame_end;
            end
            ST_FDIV: o_cmd.fdiv_step = 1'b1;
            ST_OUT: begin
                o_cmd.out_load = i_out_free;
                o_cmd.frame_clear = i_out_free;
            end
            default: ;
        endcase
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> (r_state == ST_IDLE))
        else $error("ready outside idle");
    a_out_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> !o_cmd.out_load)
        else $error("double result");
    a_div_follow: assert property (@(posedge i_clk) disable iff (!i_rst_n || i_cfg_we)
        o_cmd.div_start |=> (r_state == ST_DIV))
        else $error("divider not entered");

endmodule

[hdl/hde_dp.sv]
module hde_dp
    import hde_pkg::*;
#(
    parameter int unsigned MAX_BINS   = MaxBinsDefault,
    parameter int unsigned MAX_LEVELS = MaxLevelsDefault
)(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [12:0]      i_cfg_data,
    input  logic [BinW-1:0]  i_bin_a,
    input  logic [BinW-1:0]  i_bin_b,
    input  t_cmd             i_cmd,
    output t_status          o_st,
    output logic [OutW-1:0]  o_distance,
    output logic             o_saturated
);

    localparam int unsigned LvlW = $clog2(MAX_LEVELS + 1);
    localparam int unsigned BinCntW = $clog2(MAX_BINS + 1);
    localparam logic [WideW-1:0] WideCap = WideW'(1) << 62;
    localparam logic [SumW-1:0] SumCap = '1;

    logic [2:0]  r_mode;
    logic [12:0] r_base;
    logic [3:0]  r_levels;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_L1;
            r_base <= 13'd256;
            r_levels <= 4'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MODE:   r_mode <= i_cfg_data[2:0];
                CFG_BASE:   r_base <= i_cfg_data;
                CFG_LEVELS: r_levels <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    logic is_inter, is_chi, is_l2, is_emd;
    logic [BinCntW-1:0] eff_base;
    logic [LvlW-1:0] eff_lv;
    assign is_inter = (r_mode == MODE_INTER);
    assign is_chi = (r_mode == MODE_CHI);
    assign is_l2 = (r_mode == MODE_L2);
    assign is_emd = (r_mode == MODE_EMD);

    always_comb begin
        if (r_base == 13'd0) eff_base = BinCntW'(1);
        else if (32'(r_base) > MAX_BINS) eff_base = BinCntW'(MAX_BINS);
        else eff_base = BinCntW'(r_base);
        if (is_inter || is_chi || r_levels == 4'd0) eff_lv = LvlW'(1);
        else if (32'(r_levels) > MAX_LEVELS) eff_lv = LvlW'(MAX_LEVELS);
        else eff_lv = LvlW'(r_levels);
    end

    logic [BinW-1:0] r_a, r_b;
    logic [BinW-1:0] d;
    assign d = (r_a > r_b) ? r_a - r_b : r_b - r_a;

    logic [SumW-1:0] r_level_sum;
    logic signed [CdW-1:0] r_cd;
    logic [WideW-1:0] r_wt;
    logic [BinCntW-1:0] r_bin, r_len;
    logic [LvlW-1:0] r_lvl;
    logic [SumW-1:0] r_term;
    logic [WideW-1:0] r_dist;

    // chi-square restoring divider: 50-bit numerator / 17-bit sum
    logic [ChiNumW-1:0] r_q;
    logic [ChiDenW:0] r_rem;
    logic [ChiDenW-1:0] r_den;
    logic [5:0] r_dcnt;
    logic [ChiDenW:0] rem_sh;
    assign rem_sh = {r_rem[ChiDenW-1:0], r_q[ChiNumW-1]};

    // isqrt, one result bit per step via bit-pair method
    logic [WideW-1:0] r_sx, r_sr, r_sbit;

    // final divider 64 / (2^L-1)
    logic [WideW-1:0] r_fq;
    logic [WideW:0] r_frem;
    logic [6:0] r_fcnt;
    logic [WideW-1:0] fden;
    logic [WideW:0] frem_sh;
    assign fden = (WideW'(1) << eff_lv) - WideW'(1);
    assign frem_sh = {r_frem[WideW-1:0], r_fq[WideW-1]};

    logic signed [CdW-1:0] cd_next;
    assign cd_next = r_cd + CdW'($signed({1'b0, r_a})) - CdW'($signed({1'b0, r_b}));

    logic [SumW-1:0] term_sel;
    logic [SumW:0] sum_add;
    logic [LvlW-1:0] lvl_next;
    logic [BinCntW-1:0] len_next;
    logic [WideW-1:0] shl_val;
    logic [LvlW-1:0] shamt;
    logic [WideW:0] wt_add;

    always_comb begin
        unique case (r_mode)
            MODE_L2:    term_sel = SumW'(d) * SumW'(d);
            MODE_EMD:   term_sel = SumW'(cd_next < 0 ? -cd_next : cd_next);
            MODE_INTER: term_sel = SumW'((r_a < r_b) ? r_a : r_b);
            default:    term_sel = SumW'(d);
        endcase
        sum_add = {1'b0, r_level_sum} + {1'b0, r_term};
        lvl_next = r_lvl + LvlW'(1);
        len_next = eff_base >> lvl_next;
        shamt = eff_lv - LvlW'(1) - r_lvl;
        if (r_dist > (WideCap >> shamt)) shl_val = WideCap;
        else shl_val = r_dist << shamt;
        wt_add = {1'b0, r_wt} + {1'b0, shl_val};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || i_cmd.frame_clear) begin
            r_level_sum <= '0;
            r_cd <= '0;
            r_wt <= '0;
            r_bin <= '0;
            r_lvl <= '0;
            r_len <= BinCntW'(0);
        end else begin
            if (i_cmd.calc_term) begin
                if (is_emd) r_cd <= cd_next;
                r_term <= term_sel;
                if (r_bin == '0 && r_lvl == '0) r_len <= eff_base;
            end
            if (i_cmd.div_step && r_dcnt == 6'd0) begin
                r_term <= (r_den == '0) ? '0 : SumW'(r_q);
            end
            if (i_cmd.acc) begin
                r_level_sum <= (r_level_sum == SumCap || sum_add[SumW]) ? SumCap
                                                                       : sum_add[SumW-1:0];
                r_bin <= r_bin + BinCntW'(1);
            end
            if (i_cmd.lvl_start) begin
                r_dist <= WideW'(r_level_sum) << 1;
                r_sx <= WideW'(r_level_sum) << 2;
                r_sr <= '0;
                r_sbit <= WideW'(1) << 62;
            end
            if (i_cmd.sqrt_step) begin
                if (r_sx >= r_sr + r_sbit) begin
                    r_sx <= r_sx - (r_sr + r_sbit);
                    r_sr <= (r_sr >> 1) + r_sbit;
                end else begin
                    r_sr <= r_sr >> 1;
                end
                r_sbit <= r_sbit >> 2;
                if (r_sbit == WideW'(1)) begin
                    r_dist <= (r_sx >= r_sr + r_sbit) ? (r_sr >> 1) + r_sbit : r_sr >> 1;
                end
            end
            if (i_cmd.wadd) begin
                r_wt <= (r_wt >= WideCap || wt_add >= {1'b0, WideCap}) ? WideCap
                                                                      : wt_add[WideW-1:0];
            end
            if (i_cmd.next_level) begin
                r_level_sum <= '0;
                r_cd <= '0;
                r_bin <= '0;
                r_lvl <= lvl_next;
                r_len <= len_next;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_a <= i_bin_a;
            r_b <= i_bin_b;
        end
        if (i_cmd.div_start) begin
            r_q <= (ChiNumW'(d) * ChiNumW'(d)) << 18;
            r_rem <= '0;
            r_den <= ChiDenW'(r_a) + ChiDenW'(r_b);
            r_dcnt <= 6'(ChiNumW);
        end else if (i_cmd.div_step && r_dcnt != 6'd0) begin
            if (rem_sh >= {1'b0, r_den}) begin
                r_rem <= rem_sh - {1'b0, r_den};
                r_q <= {r_q[ChiNumW-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh;
                r_q <= {r_q[ChiNumW-2:0], 1'b0};
            end
            r_dcnt <= r_dcnt - 6'd1;
        end
        if (i_cmd.fdiv_start) begin
            r_fq <= r_wt;
            r_frem <= '0;
            r_fcnt <= 7'(WideW);
        end else if (i_cmd.fdiv_step && r_fcnt != 7'd0) begin
            if (frem_sh >= {1'b0, fden}) begin
                r_frem <= frem_sh - {1'b0, fden};
                r_fq <= {r_fq[WideW-2:0], 1'b1};
            end else begin
                r_frem <= frem_sh;
                r_fq <= {r_fq[WideW-2:0], 1'b0};
            end
            r_fcnt <= r_fcnt - 7'd1;
        end
    end

    // final value
    logic [WideW-1:0] res_u;
    logic signed [WideW:0] res_s;
    logic [WideW:0] inter_scaled;
    logic sat;
    localparam logic signed [WideW:0] OutMax = (65'sd1 <<< (OutW - 1)) - 65'sd1;
    always_comb begin
        inter_scaled = {16'b0, r_level_sum, 1'b0};
        res_u = r_fq;
        if (is_chi) begin
            res_s = $signed({17'b0, r_level_sum >> 16});
        end else if (is_inter) begin
            res_s = $signed(65'd65536) - $signed(inter_scaled);
        end else begin
            res_s = $signed({1'b0, res_u});
        end
        sat = 1'b0;
        if (res_s > OutMax) begin
            res_s = OutMax;
            sat = 1'b1;
        end else if (res_s < -OutMax - 65'sd1) begin
            res_s = -OutMax - 65'sd1;
            sat = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            o_distance <= res_s[OutW-1:0];
            o_saturated <= sat;
        end
    end

    always_comb begin
        o_st.div_done = (r_dcnt == 6'd0);
        o_st.is_chi = is_chi;
        o_st.is_l2 = is_l2;
        o_st.single = is_chi || is_inter;
        o_st.level_end = (r_bin + BinCntW'(1) >= ((r_bin == '0 && r_lvl == '0) ? eff_base
                                                                                : r_len));
        o_st.frame_end = (lvl_next >= eff_lv) || (len_next == '0);
        o_st.sqrt_done = (r_sbit == '0);
        o_st.fdiv_done = (r_fcnt == 7'd0);
    end

    a_lvl_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.next_level |-> (r_lvl < eff_lv))
        else $error("level overrun");
    a_wt_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wt <= WideCap)
        else $error("weighted total above cap");
    a_sat_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load && !sat |-> (res_s <= OutMax))
        else $error("saturation flag mismatch");

endmodule

[hdl/histogram_distance_engine_core.sv]
// Each bin pair passes the accept, term and accumulate states; chi-square adds a serial
// divide per bin. In L1, L2 and EMD a level end adds level start, weighted add and next
// level, with a square root for L2, and the frame end adds a serial divide by the weight
// sum; then an output state. One bin pair at a time: a new one waits until the last is done.
// Reset (synchronous, active low) sets mode L1, 256 base bins, one level, clears
// the frame. Any configuration write discards the frame in progress.
module histogram_distance_engine_core
    import hde_pkg::*;
#(
    parameter int unsigned MAX_BINS   = MaxBinsDefault,
    parameter int unsigned MAX_LEVELS = MaxLevelsDefault
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [12:0] i_cfg_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // bin_a[15:0], bin_b[31:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // distance[47:0]
    output logic        m_axis_tuser    // saturated
);

    t_cmd cmd;
    t_status st;
    logic r_valid;

    hde_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_in_valid(s_axis_tvalid), .i_out_free(!r_valid || m_axis_tready),
        .i_st(st), .o_in_ready(s_axis_tready), .o_cmd(cmd)
    );

    hde_dp #(.MAX_BINS(MAX_BINS), .MAX_LEVELS(MAX_LEVELS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_bin_a(s_axis_tdata[15:0]), .i_bin_b(s_axis_tdata[31:16]),
        .i_cmd(cmd), .o_st(st),
        .o_distance(m_axis_tdata), .o_saturated(m_axis_tuser)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (cmd.out_load) begin
            r_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_valid <= 1'b0;
        end
    end
    assign m_axis_tvalid = r_valid;

endmodule

[tb/sv/histogram_distance_engine_core_tb.sv]
`timescale 1ns / 100ps

module histogram_distance_engine_core_tb;
    import hde_pkg::*;

    localparam logic [1:0] CFG_SPARE = 2'd3;
    localparam logic [63:0] WIDE_CAP = 64'd1 << 62;
    localparam logic [63:0] SUM_CAP = (64'd1 << 48) - 64'd1;
    localparam longint OUT_MAX = (longint'(1) << 47) - 1;
    localparam longint OUT_MIN = -OUT_MAX - 1;
    localparam int DRAIN_CYCLES = 400;

    typedef struct packed {
        logic [15:0] b;
        logic [15:0] a;
    } bin_pair_t;

    typedef struct packed {
        logic        sat;
        logic [47:0] dist_q;
    } distance_t;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [12:0] i_cfg_data;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic m_axis_tuser;

    histogram_distance_engine_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    bin_pair_t pending_bins[$];
    distance_t expected_dist[$];
    bit req_busy;
    int send_idle_pct;
    int recv_stall_pct;
    int fail_count;
    int bins_queued;

    // predictor state
    logic [2:0]  pm_mode;
    logic [12:0] pm_base;
    logic [3:0]  pm_levels;
    logic [63:0] pm_level_sum;
    longint      pm_cum_diff;
    logic [63:0] pm_weighted;
    logic [63:0] pm_bin_idx;
    logic [63:0] pm_level_idx;
    logic [63:0] pm_level_len;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic logic [63:0] eff_base_bins();
        if (pm_base == 0) return 64'd1;
        if (pm_base > MaxBinsDefault) return 64'(MaxBinsDefault);
        return 64'(pm_base);
    endfunction

    function automatic logic [63:0] eff_level_count();
        logic [63:0] n;
        n = 64'(pm_levels);
        if (pm_mode == MODE_INTER || pm_mode == MODE_CHI) return 64'd1;
        if (n == 0) n = 64'd1;
        if (n > MaxLevelsDefault) n = 64'(MaxLevelsDefault);
        return n;
    endfunction

    function automatic logic [63:0] add_clamped(logic [63:0] x, logic [63:0] y,
                                                logic [63:0] cap);
        if (x >= cap || y >= cap - x) return cap;
        return x + y;
    endfunction

    function automatic logic [63:0] shift_clamped(logic [63:0] v, int unsigned s,
                                                  logic [63:0] cap);
        if (s >= 64) return (v != 0) ? cap : 64'd0;
        if (v > (cap >> s)) return cap;
        return v << s;
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] x);
        logic [63:0] r;
        logic [63:0] bt;
        r = 0;
        bt = 64'd1 << 62;
        while (bt > x) bt >>= 2;
        while (bt != 0) begin
            if (x >= r + bt) begin
                x = x - (r + bt);
                r = (r >> 1) + bt;
            end else begin
                r = r >> 1;
            end
            bt >>= 2;
        end
        return r;
    endfunction

    task automatic restart_frame();
        pm_level_sum = 0;
        pm_cum_diff = 0;
        pm_weighted = 0;
        pm_bin_idx = 0;
        pm_level_idx = 0;
        pm_level_len = eff_base_bins();
    endtask

    task automatic predict_config(logic [1:0] idx, logic [12:0] val);
        case (idx)
            CFG_MODE:   pm_mode = val[2:0];
            CFG_BASE:   pm_base = val;
            CFG_LEVELS: pm_levels = val[3:0];
            default: ;
        endcase
        restart_frame();
    endtask

    task automatic predict_bin(bin_pair_t p);
        logic [63:0] a, b, d, term, lv, lvl_dist, x;
        longint res;
        bit sat;
        distance_t e;
        a = 64'(p.a);
        b = 64'(p.b);
        d = (a > b) ? a - b : b - a;
        lv = eff_level_count();
        term = 0;
        case (pm_mode)
            MODE_L2: term = d * d;
            MODE_EMD: begin
                pm_cum_diff += longint'(a) - longint'(b);
                term = (pm_cum_diff < 0) ? 64'(-pm_cum_diff) : 64'(pm_cum_diff);
            end
            MODE_INTER: term = (a < b) ? a : b;
            MODE_CHI: if (a + b != 0) term = ((64'd2 * d * d) << (32 - BinFracBits)) / (a + b);
            default: term = d;
        endcase
        pm_level_sum = add_clamped(pm_level_sum, term, SUM_CAP);
        pm_bin_idx++;
        if (pm_bin_idx < pm_level_len) return;
        if (pm_mode == MODE_INTER) begin
            res = 65536 - longint'(shift_clamped(pm_level_sum, 16 - BinFracBits, WIDE_CAP));
            restart_frame();
        end else if (pm_mode == MODE_CHI) begin
            res = longint'(pm_level_sum >> 16);
            restart_frame();
        end else begin
            if (pm_mode == MODE_L2) begin
                x = shift_clamped(pm_level_sum, 32 - 2 * BinFracBits, '1);
                lvl_dist = int_sqrt(x);
            end else begin
                lvl_dist = shift_clamped(pm_level_sum, 16 - BinFracBits, WIDE_CAP);
            end
            pm_weighted = add_clamped(pm_weighted,
                shift_clamped(lvl_dist, int'(lv - 1 - pm_level_idx), WIDE_CAP), WIDE_CAP);
            pm_level_sum = 0;
            pm_cum_diff = 0;
            pm_bin_idx = 0;
            pm_level_idx++;
            pm_level_len = eff_base_bins() >> pm_level_idx;
            if (pm_level_idx < lv && pm_level_len != 0) return;
            res = longint'(pm_weighted / ((64'd1 << lv) - 1));
            restart_frame();
        end
        sat = 1'b0;
        if (res > OUT_MAX) begin
            res = OUT_MAX;
            sat = 1'b1;
        end
        if (res < OUT_MIN) begin
            res = OUT_MIN;
            sat = 1'b1;
        end
        e.dist_q = res[47:0];
        e.sat = sat;
        expected_dist.push_back(e);
    endtask

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        fail_count++;
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            predict_bin(bin_pair_t'(s_axis_tdata));
            req_busy = 1'b0;
        end
    end

    always @(negedge i_clk) begin
        if (!req_busy) begin
            if (i_rst_n && pending_bins.size() > 0
                    && $urandom_range(99) >= send_idle_pct) begin
                s_axis_tdata <= pending_bins.pop_front();
                s_axis_tvalid <= 1'b1;
                req_busy = 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        distance_t e;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_dist.size() == 0) begin
                report_mismatch($sformatf("unexpected result %h", m_axis_tdata));
            end else begin
                e = expected_dist.pop_front();
                if (m_axis_tdata !== e.dist_q)
                    report_mismatch($sformatf("distance %h, want %h", m_axis_tdata, e.dist_q));
                if (m_axis_tuser !== e.sat)
                    report_mismatch($sformatf("saturated %b, want %b", m_axis_tuser, e.sat));
            end
        end
    end

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic wait_drained();
        while (pending_bins.size() > 0 || req_busy || expected_dist.size() > 0)
            @(negedge i_clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [12:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        @(posedge i_clk);
        predict_config(idx, val);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    function automatic logic [15:0] rand_bin();
        case ($urandom_range(7))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return 16'(1 << $urandom_range(15));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic int bins_per_frame();
        int n, lv, total;
        n = int'(eff_base_bins());
        lv = int'(eff_level_count());
        total = 0;
        for (int i = 0; i < lv; i++) total += n >> i;
        return total;
    endfunction

    task automatic push_bin(logic [15:0] a, logic [15:0] b);
        bin_pair_t p;
        p.a = a;
        p.b = b;
        pending_bins.push_back(p);
        bins_queued++;
    endtask

    task automatic run_setup(logic [2:0] md, logic [12:0] base, logic [3:0] lv,
                             int frames, bit ragged);
        int n;
        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        write_reg(CFG_MODE, 13'(md));
        write_reg(CFG_BASE, base);
        write_reg(CFG_LEVELS, 13'(lv));
        if ($urandom_range(5) == 0) write_reg(CFG_SPARE, 13'($urandom));
        n = bins_per_frame() * frames;
        if (ragged) n += $urandom_range(1, 3);
        for (int i = 0; i < n; i++) push_bin(rand_bin(), rand_bin());
        wait_drained();
    endtask

    initial begin
        int ph;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = '0;
        i_cfg_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        req_busy = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fail_count = 0;
        bins_queued = 0;
        pm_mode = MODE_L1;
        pm_base = 13'd256;
        pm_levels = 4'd1;
        restart_frame();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: reset settings with a 4-bin frame, extremes per mode
        write_reg(CFG_BASE, 13'd4);
        push_bin(16'h0000, 16'h0000);
        push_bin(16'hFFFF, 16'h0000);
        push_bin(16'h0000, 16'hFFFF);
        push_bin(16'hFFFF, 16'hFFFF);
        wait_drained();
        for (int m = 0; m < 8; m++) begin
            repeat (DRAIN_CYCLES) @(negedge i_clk);
            write_reg(CFG_MODE, 13'(m));
            write_reg(CFG_BASE, 13'd2);
            write_reg(CFG_LEVELS, 13'd2);
            push_bin(16'h0000, 16'h0000);
            push_bin(16'hFFFF, 16'h0000);
            push_bin(16'h8000, 16'h7FFF);
            wait_drained();
        end
        // clamped base and levels, empty trailing levels
        run_setup(MODE_L1, 13'd0, 4'd0, 2, 1'b0);
        run_setup(MODE_EMD, 13'd3, 4'd15, 2, 1'b0);
        run_setup(MODE_L2, 13'd1, 4'd8, 1, 1'b0);
        run_setup(MODE_L1, 13'd8191, 4'd1, 0, 1'b1);
        run_setup(MODE_INTER, 13'd4096, 4'd7, 0, 1'b1);

        ph = 0;
        while (bins_queued < 1650) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
                default: begin send_idle_pct = 31; recv_stall_pct = 31; end
            endcase
            run_setup(3'($urandom_range(7)),
                      ($urandom_range(9) == 0) ? 13'($urandom_range(13, 40))
                                               : 13'($urandom_range(1, 12)),
                      4'($urandom_range(15)), $urandom_range(1, 4),
                      $urandom_range(7) == 0);
            ph++;
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #40ms;
        $display("simulation failed");
        $finish;
    end

endmodule
